// ===== hdl/hashed_bucket_fifo_store_macros.svh =====
// assertion macros for the hashed bucket fifo store
// expects i_clk and active-low i_rst_n in the including module
`ifndef HASHED_BUCKET_FIFO_STORE_MACROS_SVH
`define HASHED_BUCKET_FIFO_STORE_MACROS_SVH

// same-cycle implication
`define HBFS_CHECK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HBFS_CHECK_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hbfs_pkg.sv =====
// shared types and constants of the hashed bucket fifo store
// no dependencies
`default_nettype none

package hbfs_pkg;

    localparam int HASH_W      = 32;
    localparam int HASH_SHIFT  = 5;
    localparam int CHAR_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int BUCKET_W    = 4;
    localparam int SLOT_W      = 4;

    // bucket modulo unit: one hex digit of the hash per step
    localparam int MOD_DIGIT_W = 4;
    localparam int MOD_STEPS   = HASH_W / MOD_DIGIT_W;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_POP_CHAR   = 2'd0,
        ST_PUSH_OK    = 2'd1,
        ST_PUSH_FULL  = 2'd2,
        ST_POP_EMPTY  = 2'd3
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/hbfs_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies; read data holds while the read enable is low
`default_nettype none

module hbfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/hbfs_mod.sv =====
// iterative remainder of a 32-bit hash by a constant modulus
// uses hbfs_pkg; one hex digit per cycle, done pulses after the last digit
`default_nettype none

module hbfs_mod #(
    parameter int MODULUS = 10,
    parameter int REM_W   = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [hbfs_pkg::HASH_W-1:0] i_value,
    output logic                            o_done,
    output logic      [REM_W-1:0]           o_rem
);

    localparam int RMW = $clog2(MODULUS) + 1;
    localparam int HW  = hbfs_pkg::HASH_W;
    localparam int DW  = hbfs_pkg::MOD_DIGIT_W;
    localparam int CNW = hbfs_pkg::MOD_CNT_W;

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [HW-1:0]  r_val;
    logic [RMW-1:0] r_rem;
    logic [RMW-1:0] step_rem;

    // restoring steps, one per bit of the current digit
    always_comb begin
        logic [RMW:0] trial;
        step_rem = r_rem;
        for (int k = 0; k < DW; k++) begin
            trial = {step_rem, r_val[HW-1-k]};
            if (trial >= (RMW+1)'(MODULUS)) begin
                trial = trial - (RMW+1)'(MODULUS);
            end
            step_rem = trial[RMW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_val  <= i_value;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= step_rem;
                r_val <= {r_val[HW-DW-1:0], {DW{1'b0}}};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNW'(hbfs_pkg::MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = REM_W'(r_rem);

endmodule

`default_nettype wire

// ===== hdl/hashed_bucket_fifo_store.sv =====
// hashed bucket fifo store: key characters are taken one per cycle while o_in_stall is low.
// after the last character: modulo of the hash, then pointer lookup and address
// setup. push result after the copy of the staged characters into the entry;
// pop emits len characters one per cycle, unless the output stalls, after the length fetch.
// throughput is set by the entry ram: one char per cycle.
// reset clears hash, staging length and pointer valid bits at once; no clearing pass.
`default_nettype none

`include "hashed_bucket_fifo_store_macros.svh"

module hashed_bucket_fifo_store #(
    parameter int NUM_BUCKETS   = 10,
    parameter int QUEUE_DEPTH   = 10,
    parameter int MAX_KEY_CHARS = 49
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_op,
    input  wire logic [hbfs_pkg::CHAR_W-1:0]   i_key_char,
    input  wire logic                          i_key_last,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [hbfs_pkg::STATUS_W-1:0] o_status,
    output logic      [hbfs_pkg::BUCKET_W-1:0] o_bucket,
    output logic      [hbfs_pkg::SLOT_W-1:0]   o_slot,
    output logic      [hbfs_pkg::CHAR_W-1:0]   o_out_char,
    output logic                               o_out_last
);

    localparam int CHW        = hbfs_pkg::CHAR_W;
    localparam int HW         = hbfs_pkg::HASH_W;
    localparam int BKW        = hbfs_pkg::BUCKET_W;
    localparam int SLW        = hbfs_pkg::SLOT_W;
    localparam int STRIDE     = MAX_KEY_CHARS + 1;
    localparam int ROWS       = NUM_BUCKETS * QUEUE_DEPTH;
    localparam int STAGE_BASE = ROWS * STRIDE;
    localparam int EDEPTH     = STAGE_BASE + MAX_KEY_CHARS;
    localparam int EAW        = $clog2(EDEPTH);
    localparam int BW         = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SW         = $clog2(QUEUE_DEPTH);
    localparam int CW         = $clog2(QUEUE_DEPTH + 1);
    localparam int LW         = $clog2(MAX_KEY_CHARS + 1);
    localparam int RW         = $clog2(ROWS);
    localparam int PW         = 2 * SW + CW;

    typedef enum logic [3:0] {
        S_IN, S_MOD, S_PTR, S_BASE, S_CPY, S_LEN, S_LENW, S_POP, S_RES
    } t_state;

    t_state             r_state;
    logic [HW-1:0]      r_hash;
    logic [LW-1:0]      r_slen;
    logic               r_op;
    logic [BW-1:0]      r_bucket;
    logic [SW-1:0]      r_slot;
    logic [RW-1:0]      r_row;
    logic [EAW-1:0]     r_base;
    hbfs_pkg::t_status  r_res_status;
    logic [LW-1:0]      r_idx;
    logic [LW-1:0]      r_didx;
    logic               r_pend;
    logic               r_first;
    logic [LW-1:0]      r_plen;
    logic               r_rv;
    logic [NUM_BUCKETS-1:0] r_pvalid;

    logic               r_ovalid;
    hbfs_pkg::t_status  r_ostatus;
    logic [BW-1:0]      r_obucket;
    logic [SW-1:0]      r_oslot;
    logic [CHW-1:0]     r_ochar;
    logic               r_olast;

    logic               in_acc;
    logic               out_free;
    logic [HW-1:0]      hash_next;
    logic               mod_done;
    logic [BW-1:0]      mod_rem;

    logic               e_wr_en;
    logic [EAW-1:0]     e_wr_addr;
    logic [CHW-1:0]     e_wr_data;
    logic               e_rd_en;
    logic [EAW-1:0]     e_rd_addr;
    logic [CHW-1:0]     e_rd_data;

    logic               p_wr_en;
    logic [PW-1:0]      p_wr_data;
    logic [PW-1:0]      p_rd_data;
    logic [PW-1:0]      ptr_word;
    logic [SW-1:0]      p_head;
    logic [SW-1:0]      p_tail;
    logic [CW-1:0]      p_cnt;
    logic               p_full;
    logic               p_empty;
    logic [SW-1:0]      head_inc;
    logic [SW-1:0]      tail_inc;

    logic               cpy_rd;
    logic               pop_move;
    logic               pop_re;
    logic [LW-1:0]      len_clamp;

    assign o_in_stall = (r_state != S_IN);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ovalid || !i_out_stall;
    assign hash_next  = (r_hash << hbfs_pkg::HASH_SHIFT) + HW'(i_key_char);

    hbfs_mod #(
        .MODULUS (NUM_BUCKETS),
        .REM_W   (BW)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc && i_key_last),
        .i_value (hash_next),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // pointer word: {count, tail, head}; unwritten buckets read as empty
    assign ptr_word = r_pvalid[r_bucket] ? p_rd_data : '0;
    assign p_head   = ptr_word[SW-1:0];
    assign p_tail   = ptr_word[2*SW-1:SW];
    assign p_cnt    = ptr_word[PW-1:2*SW];
    assign p_full   = (p_cnt >= CW'(QUEUE_DEPTH));
    assign p_empty  = (p_cnt == '0);
    assign head_inc = (p_head == SW'(QUEUE_DEPTH - 1)) ? '0 : p_head + 1'b1;
    assign tail_inc = (p_tail == SW'(QUEUE_DEPTH - 1)) ? '0 : p_tail + 1'b1;
    assign p_wr_en  = (r_state == S_PTR) && ((r_op == hbfs_pkg::OP_PUSH) ? !p_full : !p_empty);
    assign p_wr_data = (r_op == hbfs_pkg::OP_PUSH) ?
                       {CW'(p_cnt + 1'b1), tail_inc, p_head} :
                       {CW'(p_cnt - 1'b1), p_tail, head_inc};

    hbfs_ram #(
        .WIDTH (PW),
        .DEPTH (NUM_BUCKETS)
    ) u_ptr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (p_wr_en),
        .i_wr_addr (r_bucket),
        .i_wr_data (p_wr_data),
        .i_rd_en   (mod_done),
        .i_rd_addr (mod_rem),
        .o_rd_data (p_rd_data)
    );

    assign cpy_rd   = (r_state == S_CPY) && (r_idx < r_slen);
    assign pop_move = (r_state == S_POP) && r_rv && out_free;
    assign pop_re   = (r_state == S_POP) && (r_idx < r_plen) && (!r_rv || pop_move);

    // stored length word, kept in range so a pop always ends
    always_comb begin
        if (e_rd_data > CHW'(MAX_KEY_CHARS)) begin
            len_clamp = LW'(MAX_KEY_CHARS);
        end else if (e_rd_data == '0) begin
            len_clamp = LW'(1);
        end else begin
            len_clamp = e_rd_data[LW-1:0];
        end
    end

    // entry ram: entries at row * STRIDE (length word, then chars), staging area on top
    always_comb begin
        e_wr_en   = 1'b0;
        e_wr_addr = EAW'(STAGE_BASE) + EAW'(r_slen);
        e_wr_data = i_key_char;
        e_rd_en   = 1'b0;
        e_rd_addr = r_base;
        unique case (r_state)
            S_IN: begin
                e_wr_en = in_acc && (r_slen < LW'(MAX_KEY_CHARS));
            end
            S_CPY: begin
                if (r_pend) begin
                    e_wr_en   = 1'b1;
                    e_wr_addr = r_base + EAW'(1) + EAW'(r_didx);
                    e_wr_data = e_rd_data;
                end else if (r_first) begin
                    e_wr_en   = 1'b1;
                    e_wr_addr = r_base;
                    e_wr_data = CHW'(r_slen);
                end
                e_rd_en   = cpy_rd;
                e_rd_addr = EAW'(STAGE_BASE) + EAW'(r_idx);
            end
            S_LEN: begin
                e_rd_en = 1'b1;
            end
            S_POP: begin
                e_rd_en   = pop_re;
                e_rd_addr = r_base + EAW'(1) + EAW'(r_idx);
            end
            default: begin
            end
        endcase
    end

    hbfs_ram #(
        .WIDTH (CHW),
        .DEPTH (EDEPTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (e_wr_en),
        .i_wr_addr (e_wr_addr),
        .i_wr_data (e_wr_data),
        .i_rd_en   (e_rd_en),
        .i_rd_addr (e_rd_addr),
        .o_rd_data (e_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IN;
            r_hash   <= '0;
            r_slen   <= '0;
            r_pvalid <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
            r_first  <= 1'b0;
            r_rv     <= 1'b0;
        end else begin
            if (out_free) begin
                r_ovalid <= 1'b0;
            end
            if (p_wr_en) begin
                r_pvalid[r_bucket] <= 1'b1;
            end
            unique case (r_state)
                S_IN: begin
                    if (in_acc) begin
                        if (r_slen < LW'(MAX_KEY_CHARS)) begin
                            r_slen <= r_slen + 1'b1;
                        end
                        if (i_key_last) begin
                            r_hash  <= '0;
                            r_op    <= i_op;
                            r_state <= S_MOD;
                        end else begin
                            r_hash <= hash_next;
                        end
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_bucket <= mod_rem;
                        r_state  <= S_PTR;
                    end
                end
                S_PTR: begin
                    if (r_op == hbfs_pkg::OP_PUSH) begin
                        r_slot <= p_tail;
                        r_row  <= RW'(r_bucket * QUEUE_DEPTH) + RW'(p_tail);
                        if (p_full) begin
                            r_res_status <= hbfs_pkg::ST_PUSH_FULL;
                            r_state      <= S_RES;
                        end else begin
                            r_res_status <= hbfs_pkg::ST_PUSH_OK;
                            r_state      <= S_BASE;
                        end
                    end else begin
                        r_slot <= p_head;
                        r_row  <= RW'(r_bucket * QUEUE_DEPTH) + RW'(p_head);
                        if (p_empty) begin
                            r_res_status <= hbfs_pkg::ST_POP_EMPTY;
                            r_state      <= S_RES;
                        end else begin
                            r_res_status <= hbfs_pkg::ST_POP_CHAR;
                            r_state      <= S_BASE;
                        end
                    end
                end
                S_BASE: begin
                    r_base <= EAW'(r_row * STRIDE);
                    r_idx  <= '0;
                    if (r_op == hbfs_pkg::OP_PUSH) begin
                        r_pend  <= 1'b0;
                        r_first <= 1'b1;
                        r_state <= S_CPY;
                    end else begin
                        r_state <= S_LEN;
                    end
                end
                S_CPY: begin
                    r_first <= 1'b0;
                    if (cpy_rd) begin
                        r_idx  <= r_idx + 1'b1;
                        r_didx <= r_idx;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend && !r_first) begin
                            r_state <= S_RES;
                        end
                    end
                end
                S_LEN: begin
                    r_state <= S_LENW;
                end
                S_LENW: begin
                    r_plen  <= len_clamp;
                    r_rv    <= 1'b0;
                    r_state <= S_POP;
                end
                S_POP: begin
                    if (pop_re) begin
                        r_idx  <= r_idx + 1'b1;
                        r_didx <= r_idx;
                        r_rv   <= 1'b1;
                    end else if (pop_move) begin
                        r_rv <= 1'b0;
                    end
                    if (pop_move) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= hbfs_pkg::ST_POP_CHAR;
                        r_obucket <= r_bucket;
                        r_oslot   <= r_slot;
                        r_ochar   <= e_rd_data;
                        r_olast   <= (r_didx + 1'b1 == r_plen);
                        if (r_didx + 1'b1 == r_plen) begin
                            r_slen  <= '0;
                            r_rv    <= 1'b0;
                            r_state <= S_IN;
                        end
                    end
                end
                S_RES: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_res_status;
                        r_obucket <= r_bucket;
                        r_oslot   <= r_slot;
                        r_ochar   <= '0;
                        r_olast   <= 1'b1;
                        r_slen    <= '0;
                        r_state   <= S_IN;
                    end
                end
                default: begin
                    r_state <= S_IN;
                end
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_bucket    = BKW'(r_obucket);
    assign o_slot      = SLW'(r_oslot);
    assign o_out_char  = r_ochar;
    assign o_out_last  = r_olast;

    `HBFS_CHECK_NXT(a_last_starts_mod, in_acc && i_key_last, (r_state == S_MOD) && (r_hash == '0), "last char did not start bucket selection")
    `HBFS_CHECK_IMP(a_mod_done_waited, mod_done, r_state == S_MOD, "modulo result outside its wait state")
    `HBFS_CHECK_IMP(a_copy_in_entries, (r_state == S_CPY) && e_wr_en, e_wr_addr < EAW'(STAGE_BASE), "copy wrote into staging area")
    `HBFS_CHECK_IMP(a_count_bound, r_state == S_PTR, p_cnt <= CW'(QUEUE_DEPTH), "bucket count above queue depth")
    `HBFS_CHECK_IMP(a_pop_index, r_state == S_POP, r_idx <= r_plen, "pop read past entry length")

endmodule

`default_nettype wire
